// ===== rtl/weighted_histogram_with_nearest_mean_unit_assert.svh =====
// Assertion macros for the weighted histogram unit.
// Depends on nothing; the files that check their own logic include it.
`ifndef WEIGHTED_HISTOGRAM_WITH_NEAREST_MEAN_UNIT_ASSERT_SVH
`define WEIGHTED_HISTOGRAM_WITH_NEAREST_MEAN_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define WHM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define WHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WHM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define WHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/whm_pkg.sv =====
// Shared constants, codes, types and helpers of the weighted histogram unit.
// Depends on nothing.
package whm_pkg;

	localparam int NUM_BINS = 64;
	localparam int BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int DEPTH    = NUM_BINS + 2;
	localparam int SLOT_W   = $clog2(DEPTH);

	localparam logic [SLOT_W-1:0] UNDER_SLOT = SLOT_W'(NUM_BINS);
	localparam logic [SLOT_W-1:0] OVER_SLOT  = SLOT_W'(NUM_BINS + 1);

	// doubled bin centres and their products with the span
	localparam int PROD_W = BIN_W + 32;
	localparam int CEN_W  = BIN_W + 34;

	// serial divider, one instance in each end
	localparam int DIV_NW = 64;
	localparam int DIV_DW = CEN_W;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	// interpolation long multiply-divide
	localparam int MAG_W  = 33;
	localparam int MAG_IW = $clog2(MAG_W);

	localparam logic [2:0] CMD_ADD        = 3'd0;
	localparam logic [2:0] CMD_QUERY      = 3'd1;
	localparam logic [2:0] CMD_READ_BIN   = 3'd2;
	localparam logic [2:0] CMD_READ_UNDER = 3'd3;
	localparam logic [2:0] CMD_READ_OVER  = 3'd4;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_DROP   = 2'd1;
	localparam logic [1:0] STS_DOMAIN = 2'd2;
	localparam logic [1:0] STS_NOSTAT = 2'd3;

	localparam logic [1:0] POL_ERROR = 2'd0;
	localparam logic [1:0] POL_KEEP  = 2'd1;

	localparam logic [1:0] REG_LOWER  = 2'd0;
	localparam logic [1:0] REG_SPAN   = 2'd1;
	localparam logic [1:0] REG_POLICY = 2'd2;

	typedef struct packed {
		logic signed [31:0] lower;
		logic [30:0]        span;
		logic [1:0]         policy;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
		logic signed [31:0] weight;
		logic               anchor;
		logic               in_domain;
		logic [SLOT_W-1:0]  slot;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_mean;
		logic [31:0]        stat_count;
		logic signed [47:0] stat_sum;
		logic signed [31:0] stat_min;
		logic signed [31:0] stat_max;
	} res_t;

	typedef struct packed {
		logic [31:0]        count;
		logic signed [47:0] sum;
		logic signed [31:0] wmin;
		logic signed [31:0] wmax;
	} entry_t;

	typedef struct packed {
		logic              go;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quotient;
	} div_rsp_t;

	// Apply sign to a magnitude quotient and saturate to 32 bits.
	function automatic logic [31:0] sat_quot(input logic neg, input logic [DIV_NW-1:0] q);
		logic [31:0] r;
		if (neg) begin
			if (q > DIV_NW'(32'h8000_0000))
				r = 32'h8000_0000;
			else
				r = ~q[31:0] + 32'd1;
		end else begin
			if (q > DIV_NW'(32'h7FFF_FFFF))
				r = 32'h7FFF_FFFF;
			else
				r = q[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/whm_if.sv =====
// Handshake channels of the weighted histogram unit: items, results, config writes.
// Depends on nothing.
interface whm_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         command;
	logic signed [31:0] sample_value;
	logic signed [31:0] sample_weight;
	logic               anchor_at_zero;
	modport source (output valid, command, sample_value, sample_weight, anchor_at_zero,
		input ready);
	modport sink (input valid, command, sample_value, sample_weight, anchor_at_zero,
		output ready);
endinterface

interface whm_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] result_mean;
	logic [31:0]        stat_count;
	logic signed [47:0] stat_sum;
	logic signed [31:0] stat_min;
	logic signed [31:0] stat_max;
	modport source (output valid, status, result_mean, stat_count, stat_sum, stat_min,
		stat_max, input ready);
	modport sink (input valid, status, result_mean, stat_count, stat_sum, stat_min,
		stat_max, output ready);
endinterface

interface whm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/weighted_histogram_with_nearest_mean_unit.sv =====
// Top level of the weighted histogram unit with nearest-mean query.
// Depends on whm_pkg, whm_if, whm_front, whm_queue and whm_back.
//
//  Channel  Dir  Payload                                                  Transfer when
//  req      in   command, sample_value, sample_weight, anchor_at_zero     valid && ready
//  rsp      out  status, result_mean, stat_count, stat_sum, min, max      valid && ready
//  cfg      in   index (0 lower, 1 span, 2 policy), data                  valid && ready
//
// Front end: an add, query or bin read at or above the left edge runs its locating divider
// (one quotient bit a cycle); other items skip it. Back end: an add updates its bin; reads
// and queries on a filled bin run the mean divider; an empty-bin query adds the neighbour
// walk (one bin a cycle), up to two mean divisions and a blend or through-origin division.
// Reset clears all control state and the per-slot valid bits; no clearing pass.
// A two-entry queue separates the ends, and the result register lets the back end
// start the next item while a result waits; each side stalls on its own.
module weighted_histogram_with_nearest_mean_unit
	import whm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	whm_in_if.sink    req,
	whm_out_if.source rsp,
	whm_cfg_if.sink   cfg
);

	logic signed [31:0] lower_q;
	logic [30:0]        span_q;
	logic [1:0]         policy_q;
	cfg_t               cfg_cur;
	logic               push_valid;
	item_t              push_item;
	logic               push_ready;
	logic               pop_valid;
	item_t              pop_item;
	logic               pop_ready;
	logic               res_valid;
	res_t               res;

	// config is always taken; write only while idle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= '0;
			span_q   <= 31'd65536;
			policy_q <= POL_ERROR;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LOWER:  lower_q  <= cfg.data;
				REG_SPAN:   span_q   <= cfg.data[30:0];
				REG_POLICY: policy_q <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// a zero span behaves as the smallest step
	assign cfg_cur.lower  = lower_q;
	assign cfg_cur.span   = (span_q == '0) ? 31'd1 : span_q;
	assign cfg_cur.policy = policy_q;

	whm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_cur),
		.req        (req),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	whm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	whm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_cur),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (rsp.ready)
	);

	// hold the result on the port until it is taken
	assign rsp.valid       = res_valid;
	assign rsp.status      = res.status;
	assign rsp.result_mean = res.result_mean;
	assign rsp.stat_count  = res.stat_count;
	assign rsp.stat_sum    = res.stat_sum;
	assign rsp.stat_min    = res.stat_min;
	assign rsp.stat_max    = res.stat_max;

endmodule

// ===== rtl/whm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on whm_pkg.
module whm_div
	import whm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] dvd_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CW'(1));
			if (busy_q) begin
				rem_q  <= fits ? DIV_DW'(trial - {1'b0, dvs_q}) : trial[DIV_DW-1:0];
				quo_q  <= {quo_q[DIV_NW-2:0], fits};
				dvd_q  <= {dvd_q[DIV_NW-2:0], 1'b0};
				cnt_q  <= cnt_q - DIV_CW'(1);
				busy_q <= cnt_q != DIV_CW'(1);
			end else if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				quo_q  <= '0;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/whm_front.sv =====
// Front end: takes items, locates the bin of the sample value and classifies it.
// Depends on whm_pkg, whm_if and whm_div.
module whm_front
	import whm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	whm_in_if.sink     req,
	output logic       push_valid,
	output item_t      push_item,
	input  logic       push_ready
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_LOC  = 2'd1;
	localparam logic [1:0] F_DIV  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0]         state_q;
	item_t              it_q;
	logic signed [32:0] offset;
	logic               needs_bin;
	div_req_t           dreq;
	div_rsp_t           drsp;

	assign offset    = {it_q.value[31], it_q.value} - {cfg.lower[31], cfg.lower};
	assign needs_bin = (it_q.cmd == CMD_ADD) || (it_q.cmd == CMD_QUERY) ||
		(it_q.cmd == CMD_READ_BIN);

	assign dreq.go       = (state_q == F_LOC) && needs_bin && !offset[32];
	assign dreq.dividend = {{(DIV_NW-33){1'b0}}, offset};
	assign dreq.divisor  = {{(DIV_DW-31){1'b0}}, cfg.span};

	whm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign req.ready  = state_q == F_IDLE;
	assign push_valid = state_q == F_PUSH;
	assign push_item  = it_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			it_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req.valid) begin
						it_q.cmd       <= req.command;
						it_q.value     <= req.sample_value;
						it_q.weight    <= req.sample_weight;
						it_q.anchor    <= req.anchor_at_zero;
						it_q.in_domain <= 1'b0;
						it_q.slot      <= UNDER_SLOT;
						state_q        <= F_LOC;
					end
				end
				F_LOC: begin
					if (needs_bin && !offset[32]) begin
						state_q <= F_DIV;
					end else begin
						// negative distance is always below bin zero; under and over reads take their own slot
						if (it_q.cmd == CMD_READ_OVER)
							it_q.slot <= OVER_SLOT;
						else
							it_q.slot <= UNDER_SLOT;
						state_q <= F_PUSH;
					end
				end
				F_DIV: begin
					if (drsp.done) begin
						if (drsp.quotient < DIV_NW'(NUM_BINS)) begin
							it_q.in_domain <= 1'b1;
							it_q.slot      <= {{(SLOT_W-BIN_W){1'b0}},
								drsp.quotient[BIN_W-1:0]};
						end else begin
							it_q.slot <= OVER_SLOT;
						end
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/whm_queue.sv =====
// Two-entry queue of classified items between front and back end.
// Depends on whm_pkg.
module whm_queue
	import whm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop_ready
);

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_item   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/whm_back.sv =====
// Back end: bin store, mean division, neighbour walk, interpolation, result register.
// Depends on whm_pkg, whm_div and the assertion macro header.
`include "weighted_histogram_with_nearest_mean_unit_assert.svh"
module whm_back
	import whm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  pop_valid,
	input  item_t pop_item,
	output logic  pop_ready,
	output logic  res_valid,
	output res_t  res,
	input  logic  res_ready
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_RD   = 5'd2;
	localparam logic [4:0] S_USE  = 5'd3;
	localparam logic [4:0] S_MDV  = 5'd4;
	localparam logic [4:0] S_SLO  = 5'd5;
	localparam logic [4:0] S_SHI  = 5'd6;
	localparam logic [4:0] S_NB   = 5'd7;
	localparam logic [4:0] S_BL0  = 5'd8;
	localparam logic [4:0] S_BL1  = 5'd9;
	localparam logic [4:0] S_BL2  = 5'd10;
	localparam logic [4:0] S_BL3  = 5'd11;
	localparam logic [4:0] S_BLA  = 5'd12;
	localparam logic [4:0] S_BLB  = 5'd13;
	localparam logic [4:0] S_BLF  = 5'd14;
	localparam logic [4:0] S_OR0  = 5'd15;
	localparam logic [4:0] S_OR1  = 5'd16;
	localparam logic [4:0] S_OR2  = 5'd17;
	localparam logic [4:0] S_OR3  = 5'd18;
	localparam logic [4:0] S_ORW  = 5'd19;
	localparam logic [4:0] S_FIN  = 5'd20;

	localparam logic [1:0] CTX_OWN = 2'd0;
	localparam logic [1:0] CTX_LO  = 2'd1;
	localparam logic [1:0] CTX_HI  = 2'd2;

	logic [4:0]         state_q;
	item_t              it_q;
	logic [SLOT_W-1:0]  addr_q;
	logic [1:0]         ctx_q;
	logic [BIN_W-1:0]   lo_q;
	logic [BIN_W-1:0]   hi_q;
	logic               has_lo_q;
	logic               has_hi_q;
	logic signed [31:0] y0_q;
	logic signed [31:0] y1_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CEN_W-1:0]   cl_q;
	logic [CEN_W-1:0]   ch_q;
	logic [CEN_W-1:0]   t_q;
	logic [CEN_W-1:0]   dx_q;
	logic [CEN_W-1:0]   r_q;
	logic [MAG_W-1:0]   mag_q;
	logic [MAG_W:0]     bq_q;
	logic [MAG_IW-1:0]  bi_q;
	logic [DIV_NW-1:0]  mprod_q;
	res_t               rs_q;
	res_t               res_q;
	logic               res_valid_q;

	// bin store: one array, one write and one registered read per cycle
	entry_t             mem_q [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	entry_t             rd_q;
	logic               rd_vld_q;
	logic               mem_we;
	entry_t             wr_data;

	div_req_t           dreq;
	div_rsp_t           drsp;
	logic [31:0]        mean_q;

	logic [47:0]        sum_mag;
	logic signed [48:0] sum_ext;
	logic [BIN_W-1:0]   lo_m1;
	logic [BIN_W-1:0]   hi_p1;
	logic [BIN_W:0]     cidx;
	logic [PROD_W-1:0]  prod_n;
	logic [CEN_W-1:0]   two_l;
	logic [CEN_W-1:0]   cen_n;
	logic [CEN_W-1:0]   two_v;
	logic [CEN_W-1:0]   ch_mag;
	logic signed [32:0] dy;
	logic signed [32:0] v2;
	logic [32:0]        mx;
	logic [31:0]        my;
	logic [CEN_W-1:0]   r_add;
	logic [CEN_W-1:0]   dx2;
	logic signed [34:0] blend_n;
	logic               res_load;

	assign pop_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_load  = (state_q == S_FIN) && (!res_valid_q || res_ready);

	// store update for an add
	assign sum_ext = {rd_q.sum[47], rd_q.sum} + {{17{it_q.weight[31]}}, it_q.weight};
	always_comb begin
		wr_data = rd_q;
		if (!rd_vld_q) begin
			wr_data.count = 32'd1;
			wr_data.sum   = {{16{it_q.weight[31]}}, it_q.weight};
			wr_data.wmin  = it_q.weight;
			wr_data.wmax  = it_q.weight;
		end else begin
			if (rd_q.count != 32'hFFFF_FFFF)
				wr_data.count = rd_q.count + 32'd1;
			if (sum_ext[48] != sum_ext[47])
				wr_data.sum = sum_ext[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
			else
				wr_data.sum = sum_ext[47:0];
			if (it_q.weight < rd_q.wmin)
				wr_data.wmin = it_q.weight;
			if (it_q.weight > rd_q.wmax)
				wr_data.wmax = it_q.weight;
		end
	end
	assign mem_we = (state_q == S_USE) && (it_q.cmd == CMD_ADD);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[addr_q] <= wr_data;
		if (state_q == S_RD)
			rd_q <= mem_q[addr_q];
	end

	// shared divider: bin means and the through-origin fraction
	assign sum_mag = rd_q.sum[47] ? 48'(-rd_q.sum) : rd_q.sum;
	assign ch_mag  = ch_q[CEN_W-1] ? CEN_W'(-ch_q) : ch_q;
	always_comb begin
		dreq.go = ((state_q == S_USE) && (it_q.cmd != CMD_ADD) && rd_vld_q) ||
			(state_q == S_OR3);
		if (state_q == S_OR3) begin
			dreq.dividend = mprod_q;
			dreq.divisor  = ch_mag;
		end else begin
			dreq.dividend = {{(DIV_NW-48){1'b0}}, sum_mag};
			dreq.divisor  = {{(DIV_DW-32){1'b0}}, rd_q.count};
		end
	end

	whm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign mean_q = sat_quot(neg_q, drsp.quotient);

	// doubled centre: 2*lower + (2*idx + 1)*span
	assign lo_m1  = lo_q - BIN_W'(1);
	assign hi_p1  = hi_q + BIN_W'(1);
	assign cidx   = {(state_q == S_BL0) ? lo_q : hi_q, 1'b1};
	assign prod_n = {{(PROD_W-BIN_W-1){1'b0}}, cidx} * {{(PROD_W-31){1'b0}}, cfg.span};
	assign two_l  = {{(CEN_W-33){cfg.lower[31]}}, cfg.lower, 1'b0};
	assign cen_n  = two_l + {{(CEN_W-PROD_W){1'b0}}, prod_q};
	assign two_v  = {{(CEN_W-33){it_q.value[31]}}, it_q.value, 1'b0};

	assign dy      = {y1_q[31], y1_q} - {y0_q[31], y0_q};
	assign v2      = {it_q.value, 1'b0};
	assign mx      = v2[32] ? 33'(-v2) : v2;
	assign my      = y1_q[31] ? 32'(-y1_q) : y1_q;
	assign r_add   = {r_q[CEN_W-2:0], 1'b0} + (mag_q[bi_q] ? t_q : '0);
	assign dx2     = {dx_q[CEN_W-2:0], 1'b0};
	assign blend_n = neg_q ? ({{3{y0_q[31]}}, y0_q} - {1'b0, bq_q}) :
		({{3{y0_q[31]}}, y0_q} + {1'b0, bq_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			it_q        <= '0;
			addr_q      <= '0;
			ctx_q       <= CTX_OWN;
			lo_q        <= '0;
			hi_q        <= '0;
			has_lo_q    <= 1'b0;
			has_hi_q    <= 1'b0;
			y0_q        <= '0;
			y1_q        <= '0;
			neg_q       <= 1'b0;
			prod_q      <= '0;
			cl_q        <= '0;
			ch_q        <= '0;
			t_q         <= '0;
			dx_q        <= '0;
			r_q         <= '0;
			mag_q       <= '0;
			bq_q        <= '0;
			bi_q        <= '0;
			mprod_q     <= '0;
			rs_q        <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;
			if (state_q == S_RD)
				rd_vld_q <= vld_q[addr_q];
			if (mem_we)
				vld_q[addr_q] <= 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						it_q    <= pop_item;
						rs_q    <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					addr_q <= it_q.slot;
					ctx_q  <= CTX_OWN;
					unique case (it_q.cmd)
						CMD_ADD: begin
							if (it_q.in_domain || cfg.policy == POL_KEEP) begin
								state_q <= S_RD;
							end else begin
								rs_q.status <= (cfg.policy == POL_ERROR) ?
									STS_DOMAIN : STS_DROP;
								state_q <= S_FIN;
							end
						end
						CMD_QUERY, CMD_READ_BIN: begin
							if (it_q.in_domain) begin
								state_q <= S_RD;
							end else begin
								rs_q.status <= STS_DOMAIN;
								state_q     <= S_FIN;
							end
						end
						CMD_READ_UNDER, CMD_READ_OVER: begin
							if (cfg.policy == POL_KEEP) begin
								state_q <= S_RD;
							end else begin
								rs_q.status <= STS_NOSTAT;
								state_q     <= S_FIN;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_RD: state_q <= S_USE;
				S_USE: begin
					if (it_q.cmd == CMD_ADD) begin
						state_q <= S_FIN;
					end else if (!rd_vld_q) begin
						// empty own bin: a query walks outward, a read shows zeros
						if (it_q.cmd == CMD_QUERY) begin
							lo_q    <= addr_q[BIN_W-1:0];
							hi_q    <= addr_q[BIN_W-1:0];
							state_q <= S_SLO;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						neg_q <= rd_q.sum[47];
						if (it_q.cmd != CMD_QUERY) begin
							rs_q.stat_count <= rd_q.count;
							rs_q.stat_sum   <= rd_q.sum;
							rs_q.stat_min   <= rd_q.wmin;
							rs_q.stat_max   <= rd_q.wmax;
						end
						state_q <= S_MDV;
					end
				end
				S_MDV: begin
					if (drsp.done) begin
						unique case (ctx_q)
							CTX_LO: begin
								y0_q <= mean_q;
								if (has_hi_q) begin
									addr_q  <= {{(SLOT_W-BIN_W){1'b0}}, hi_q};
									ctx_q   <= CTX_HI;
									state_q <= S_RD;
								end else begin
									rs_q.result_mean <= mean_q;
									state_q          <= S_FIN;
								end
							end
							CTX_HI: begin
								y1_q <= mean_q;
								if (has_lo_q) begin
									state_q <= S_BL0;
								end else if (it_q.anchor) begin
									state_q <= S_OR0;
								end else begin
									rs_q.result_mean <= mean_q;
									state_q          <= S_FIN;
								end
							end
							default: begin
								rs_q.result_mean <= mean_q;
								state_q          <= S_FIN;
							end
						endcase
					end
				end
				S_SLO: begin
					if (lo_q == '0) begin
						has_lo_q <= 1'b0;
						state_q  <= S_SHI;
					end else begin
						lo_q <= lo_m1;
						if (vld_q[{{(SLOT_W-BIN_W){1'b0}}, lo_m1}]) begin
							has_lo_q <= 1'b1;
							state_q  <= S_SHI;
						end
					end
				end
				S_SHI: begin
					if (hi_q == BIN_W'(NUM_BINS - 1)) begin
						has_hi_q <= 1'b0;
						state_q  <= S_NB;
					end else begin
						hi_q <= hi_p1;
						if (vld_q[{{(SLOT_W-BIN_W){1'b0}}, hi_p1}]) begin
							has_hi_q <= 1'b1;
							state_q  <= S_NB;
						end
					end
				end
				S_NB: begin
					if (has_lo_q) begin
						addr_q  <= {{(SLOT_W-BIN_W){1'b0}}, lo_q};
						ctx_q   <= CTX_LO;
						state_q <= S_RD;
					end else if (has_hi_q) begin
						addr_q  <= {{(SLOT_W-BIN_W){1'b0}}, hi_q};
						ctx_q   <= CTX_HI;
						state_q <= S_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_BL0: begin
					prod_q  <= prod_n;
					state_q <= S_BL1;
				end
				S_BL1: begin
					cl_q    <= cen_n;
					prod_q  <= prod_n;
					state_q <= S_BL2;
				end
				S_BL2: begin
					ch_q    <= cen_n;
					state_q <= S_BL3;
				end
				S_BL3: begin
					t_q     <= two_v - cl_q;
					dx_q    <= ch_q - cl_q;
					neg_q   <= dy[32];
					mag_q   <= dy[32] ? 33'(-dy) : dy;
					r_q     <= '0;
					bq_q    <= '0;
					bi_q    <= MAG_IW'(MAG_W - 1);
					state_q <= S_BLA;
				end
				S_BLA: begin
					r_q     <= r_add;
					bq_q    <= {bq_q[MAG_W-1:0], 1'b0};
					state_q <= S_BLB;
				end
				S_BLB: begin
					// remainder is below three divisors here
					if (r_q >= dx2) begin
						r_q  <= r_q - dx2;
						bq_q <= bq_q + (MAG_W+1)'(2);
					end else if (r_q >= dx_q) begin
						r_q  <= r_q - dx_q;
						bq_q <= bq_q + (MAG_W+1)'(1);
					end
					if (bi_q == '0) begin
						state_q <= S_BLF;
					end else begin
						bi_q    <= bi_q - MAG_IW'(1);
						state_q <= S_BLA;
					end
				end
				S_BLF: begin
					rs_q.result_mean <= blend_n[31:0];
					state_q          <= S_FIN;
				end
				S_OR0: begin
					prod_q  <= prod_n;
					state_q <= S_OR1;
				end
				S_OR1: begin
					ch_q    <= cen_n;
					state_q <= S_OR2;
				end
				S_OR2: begin
					if (ch_q == '0) begin
						rs_q.result_mean <= y1_q;
						state_q          <= S_FIN;
					end else begin
						mprod_q <= {32'd0, my} * {31'd0, mx};
						neg_q   <= y1_q[31] ^ it_q.value[31] ^ ch_q[CEN_W-1];
						state_q <= S_OR3;
					end
				end
				S_OR3: state_q <= S_ORW;
				S_ORW: begin
					if (drsp.done) begin
						rs_q.result_mean <= mean_q;
						state_q          <= S_FIN;
					end
				end
				S_FIN: begin
					if (!res_valid_q || res_ready) begin
						res_q   <= rs_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`WHM_ASSERT_NOW(a_write_on_add, clk, arst_n, mem_we, it_q.cmd == CMD_ADD)
	`WHM_ASSERT_NOW(a_query_no_stats, clk, arst_n, res_load && it_q.cmd == CMD_QUERY, rs_q.stat_count == '0 && rs_q.stat_sum == '0)
	`WHM_ASSERT_NOW(a_error_zero_mean, clk, arst_n, res_load && rs_q.status != STS_OK, rs_q.result_mean == '0)
	`WHM_ASSERT_NEXT(a_fin_waits, clk, arst_n, state_q == S_FIN && res_valid_q && !res_ready, state_q == S_FIN)

endmodule
